>>> hw/rtl/line_folder_unit_defines.svh
// Assertion macros shared by the line folder RTL.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef LINE_FOLDER_UNIT_DEFINES_SVH
`define LINE_FOLDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LFU_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("line folder assertion failed");
`define LFU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line folder assertion failed");
`else
`define LFU_ASSERT_ALWAYS(lbl, expr)
`define LFU_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/lfu_pkg.sv
// Package for the line folder: character codes, field widths, register
// indexes and the result push struct. No dependencies.
package lfu_pkg;

  localparam int FC_W = 6;  // fold_column register width
  localparam int TS_W = 5;  // tab_stop register width

  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_SP  = 8'd32;

  localparam logic REG_FOLD_COLUMN = 1'b0;
  localparam logic REG_TAB_STOP    = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } push_t;

endpackage

>>> hw/rtl/line_folder_unit.sv
// Line folder top level: one item at a time, in_tready is low until it is done.
// Each output stall holds the sequencer until the output register is free.
// Reset (rst_n, synchronous, active low) empties the line, clears the blank
// mark and loads fold_column 5 and tab_stop 4; store contents are not cleared.
module line_folder_unit #(
  parameter int LINE_MAX = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input stream.
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic       in_tlast,   // end_of_text
  // Result stream.
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_out
  output logic       out_tlast,  // last_of_run
  // Configuration writes.
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_wdata
);

  import lfu_pkg::*;

  localparam int AW = $clog2(LINE_MAX);

  logic [FC_W-1:0] fold_column_r;
  logic [TS_W-1:0] tab_stop_r;

  logic            out_valid_r;
  logic [7:0]      out_data_r;
  logic            out_last_r;
  logic            out_free;

  push_t           push;
  logic            st_we;
  logic [AW-1:0]   st_waddr;
  logic [7:0]      st_wdata;
  logic            st_re;
  logic [AW-1:0]   st_raddr;
  logic [7:0]      st_rdata;

  // Configuration registers. Writes must be made only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_column_r <= FC_W'(5);
      tab_stop_r    <= TS_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOLD_COLUMN: fold_column_r <= cfg_wdata;
        REG_TAB_STOP:    tab_stop_r    <= cfg_wdata[TS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The output register decouples the sequencer from the result stream: a new
  // byte may be loaded in the same cycle the held one is taken by a transfer.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (push.valid) begin
      out_data_r <= push.data;
      out_last_r <= push.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The sequencer owns the line state and drives the store; the store holds the
  // line bytes with a registered read.
  lfu_ctrl #(
    .LINE_MAX(LINE_MAX)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_char    (in_tdata),
    .in_eot     (in_tlast),
    .fold_column(fold_column_r),
    .tab_stop   (tab_stop_r),
    .out_free   (out_free),
    .push       (push),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_wdata   (st_wdata),
    .st_re      (st_re),
    .st_raddr   (st_raddr),
    .st_rdata   (st_rdata)
  );

  lfu_store #(
    .DEPTH(LINE_MAX)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .re   (st_re),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

endmodule

>>> hw/rtl/lfu_store.sv
// Line store of the line folder: one write port, one registered read port.
// No dependencies.
module lfu_store #(
  parameter int DEPTH = 63,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/lfu_ctrl.sv
// Sequencer of the line folder: stores bytes, expands tabs, emits and shifts
// the line through the store. Depends on lfu_pkg and the assertion macro header.
`include "line_folder_unit_defines.svh"

module lfu_ctrl #(
  parameter int LINE_MAX = 63,
  localparam int AW = $clog2(LINE_MAX),
  localparam int CW = $clog2(LINE_MAX + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_char,
  input  logic                    in_eot,
  input  logic [lfu_pkg::FC_W-1:0] fold_column,
  input  logic [lfu_pkg::TS_W-1:0] tab_stop,
  input  logic                    out_free,
  output lfu_pkg::push_t          push,
  output logic                    st_we,
  output logic [AW-1:0]           st_waddr,
  output logic [7:0]              st_wdata,
  output logic                    st_re,
  output logic [AW-1:0]           st_raddr,
  input  logic [7:0]              st_rdata
);

  import lfu_pkg::*;

  localparam int MW = (CW > TS_W) ? CW : TS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LD, S_NL, S_SH_RD, S_SH_WR, S_APPEND, S_MOD, S_TAB
  } state_t;

  typedef enum logic [1:0] {
    AFT_CLEAR, AFT_REFILL, AFT_SHIFT
  } after_t;

  state_t          state_r, state_nxt;
  after_t          after_r, after_nxt;
  logic [7:0]      ch_r, ch_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [AW-1:0]   lbp_r, lbp_nxt;
  logic            blank_r, blank_nxt;
  logic [CW-1:0]   len_r, len_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   dst_r, dst_nxt;
  logic [MW-1:0]   rem_r, rem_nxt;
  logic [TS_W-1:0] cnt_r, cnt_nxt;

  logic [CW-1:0]   col;
  logic [TS_W-1:0] ts;
  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   dst_inc;
  logic [CW-1:0]   fill_inc;

  // Effective column and tab stop after clamping.
  always_comb begin
    if (fold_column == '0) begin
      col = CW'(1);
    end else if (fold_column > FC_W'(LINE_MAX)) begin
      col = CW'(LINE_MAX);
    end else begin
      col = CW'(fold_column);
    end
    ts = (tab_stop == '0) ? TS_W'(1) : tab_stop;
  end

  assign idx_inc  = idx_r + CW'(1);
  assign dst_inc  = dst_r + CW'(1);
  assign fill_inc = fill_r + CW'(1);

  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    ch_nxt    = ch_r;
    fill_nxt  = fill_r;
    lbp_nxt   = lbp_r;
    blank_nxt = blank_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    dst_nxt   = dst_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    push      = '0;
    st_we     = 1'b0;
    st_waddr  = fill_r[AW-1:0];
    st_wdata  = ch_r;
    st_re     = 1'b0;
    st_raddr  = idx_r[AW-1:0];
    in_ready  = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt  = in_char;
          idx_nxt = '0;
          if (in_eot) begin
            lbp_nxt   = '0;
            blank_nxt = 1'b0;
            len_nxt   = fill_r;
            after_nxt = AFT_CLEAR;
            if (fill_r != '0) begin
              state_nxt = S_RD;
            end
          end else if (in_char == CH_NL) begin
            lbp_nxt   = '0;
            blank_nxt = 1'b0;
            len_nxt   = fill_r;
            after_nxt = AFT_CLEAR;
            state_nxt = (fill_r == '0) ? S_NL : S_RD;
          end else if (in_char == CH_TAB) begin
            if (fill_r < col) begin
              rem_nxt   = MW'(fill_r);
              state_nxt = S_MOD;
            end
          end else if (fill_r >= col) begin
            if (!blank_r || (CW'(lbp_r) >= fill_r)) begin
              len_nxt   = fill_r;
              after_nxt = AFT_REFILL;
            end else begin
              len_nxt   = CW'(lbp_r) + CW'(1);
              after_nxt = AFT_SHIFT;
            end
            state_nxt = S_RD;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end
      S_RD: begin
        st_re     = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        if (out_free) begin
          push.valid = 1'b1;
          push.data  = st_rdata;
          idx_nxt    = idx_inc;
          state_nxt  = (idx_inc == len_r) ? S_NL : S_RD;
        end
      end
      S_NL: begin
        if (out_free) begin
          push.valid = 1'b1;
          push.data  = CH_NL;
          push.last  = 1'b1;
          case (after_r)
            AFT_CLEAR: begin
              fill_nxt  = '0;
              state_nxt = S_IDLE;
            end
            AFT_REFILL: begin
              fill_nxt  = '0;
              state_nxt = S_APPEND;
            end
            AFT_SHIFT: begin
              // The remainder starts just past the last blank, which is len_r.
              blank_nxt = 1'b0;
              lbp_nxt   = '0;
              dst_nxt   = '0;
              idx_nxt   = len_r;
              if (len_r < fill_r) begin
                state_nxt = S_SH_RD;
              end else begin
                fill_nxt  = '0;
                state_nxt = S_APPEND;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SH_RD: begin
        st_re     = 1'b1;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        st_we    = 1'b1;
        st_waddr = dst_r[AW-1:0];
        st_wdata = st_rdata;
        if (st_rdata == CH_SP) begin
          lbp_nxt   = dst_r[AW-1:0];
          blank_nxt = 1'b1;
        end
        dst_nxt = dst_inc;
        idx_nxt = idx_inc;
        if (idx_inc < fill_r) begin
          state_nxt = S_SH_RD;
        end else begin
          fill_nxt  = dst_inc;
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        if (fill_r < CW'(LINE_MAX)) begin
          st_we    = 1'b1;
          st_waddr = fill_r[AW-1:0];
          st_wdata = ch_r;
          if (ch_r == CH_SP) begin
            lbp_nxt   = fill_r[AW-1:0];
            blank_nxt = 1'b1;
          end
          fill_nxt = fill_inc;
        end
        state_nxt = S_IDLE;
      end
      S_MOD: begin
        // Remainder of the fill count by the tab stop, one subtraction a cycle.
        if (rem_r >= MW'(ts)) begin
          rem_nxt = rem_r - MW'(ts);
        end else begin
          cnt_nxt   = ts - TS_W'(rem_r);
          state_nxt = S_TAB;
        end
      end
      S_TAB: begin
        if ((cnt_r != '0) && (fill_r < col)) begin
          st_we     = 1'b1;
          st_waddr  = fill_r[AW-1:0];
          st_wdata  = CH_SP;
          lbp_nxt   = fill_r[AW-1:0];
          blank_nxt = 1'b1;
          fill_nxt  = fill_inc;
          cnt_nxt   = cnt_r - TS_W'(1);
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= AFT_CLEAR;
      fill_r  <= '0;
      lbp_r   <= '0;
      blank_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      fill_r  <= fill_nxt;
      lbp_r   <= lbp_nxt;
      blank_r <= blank_nxt;
    end
    ch_r  <= ch_nxt;
    len_r <= len_nxt;
    idx_r <= idx_nxt;
    dst_r <= dst_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  `LFU_ASSERT_ALWAYS(a_fill_bound, fill_r <= CW'(LINE_MAX))
  `LFU_ASSERT_IMPL(a_blank_in_line, (state_r == S_IDLE) && blank_r, CW'(lbp_r) < fill_r)
  `LFU_ASSERT_IMPL(a_close_is_nl, push.valid && push.last, push.data == CH_NL)
  `LFU_ASSERT_IMPL(a_push_has_room, push.valid, out_free)

endmodule
